/* rtl/roman_numeral_encoder_top_macros.svh */
// Assertion macros for the Roman numeral encoder.
// Used by the top level; the macros expect clk and arst_n in scope.
`ifndef ROMAN_NUMERAL_ENCODER_TOP_MACROS_SVH
`define ROMAN_NUMERAL_ENCODER_TOP_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define RNE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define RNE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rne_pkg.sv */
// Shared types, constants and lookup functions for the Roman numeral encoder.
// No dependencies; used by the interfaces, the digit splitter and the top level.
`timescale 1ns / 1ps

package rne_pkg;

	localparam int VALUE_W  = 12;
	localparam int SYMBOL_W = 7;

	localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

	// ASCII codes of the Roman symbols.
	localparam logic [SYMBOL_W-1:0] SYM_I = 7'd73;
	localparam logic [SYMBOL_W-1:0] SYM_V = 7'd86;
	localparam logic [SYMBOL_W-1:0] SYM_X = 7'd88;
	localparam logic [SYMBOL_W-1:0] SYM_L = 7'd76;
	localparam logic [SYMBOL_W-1:0] SYM_C = 7'd67;
	localparam logic [SYMBOL_W-1:0] SYM_D = 7'd68;
	localparam logic [SYMBOL_W-1:0] SYM_M = 7'd77;

	// Decimal places, least significant first.
	localparam logic [1:0] PLACE_ONES      = 2'd0;
	localparam logic [1:0] PLACE_TENS      = 2'd1;
	localparam logic [1:0] PLACE_HUNDREDS  = 2'd2;
	localparam logic [1:0] PLACE_THOUSANDS = 2'd3;

	typedef logic [3:0] digit_t;

	// Role of one character within a digit's pattern.
	typedef enum logic [1:0] {
		CODE_NONE,
		CODE_UNIT,
		CODE_FIVE,
		CODE_TEN
	} code_t;

	// Result handed from the digit splitter to the sequencer.
	typedef struct packed {
		logic            done;
		digit_t [3:0]    digit;
	} split_t;

	// Weight of a place that the splitter subtracts.
	function automatic logic [VALUE_W-1:0] place_weight(input logic [1:0] place);
		logic [VALUE_W-1:0] w;
		case (place)
			PLACE_THOUSANDS: w = 12'd1000;
			PLACE_HUNDREDS:  w = 12'd100;
			PLACE_TENS:      w = 12'd10;
			default:         w = 12'd1;
		endcase
		return w;
	endfunction

	// Character k of the pattern for one decimal digit.
	function automatic code_t digit_code(input digit_t d, input logic [1:0] k);
		code_t c;
		c = CODE_NONE;
		case (d)
			4'd1: if (k == 2'd0) c = CODE_UNIT;
			4'd2: if (k <= 2'd1) c = CODE_UNIT;
			4'd3: if (k <= 2'd2) c = CODE_UNIT;
			4'd4: begin
				if (k == 2'd0) c = CODE_UNIT;
				else if (k == 2'd1) c = CODE_FIVE;
			end
			4'd5: if (k == 2'd0) c = CODE_FIVE;
			4'd6, 4'd7, 4'd8: begin
				if (k == 2'd0) c = CODE_FIVE;
				else if (k <= d[1:0] - 2'd1 + {1'b0, d[3]} + 2'd0 && d != 4'd8) c = CODE_UNIT;
				else if (d == 4'd8) c = CODE_UNIT;
			end
			4'd9: begin
				if (k == 2'd0) c = CODE_UNIT;
				else if (k == 2'd1) c = CODE_TEN;
			end
			default: c = CODE_NONE;
		endcase
		return c;
	endfunction

	// ASCII symbol for a pattern character at a place.
	function automatic logic [SYMBOL_W-1:0] place_symbol(input logic [1:0] place,
			input code_t c);
		logic [SYMBOL_W-1:0] s;
		case (place)
			PLACE_ONES:     s = (c == CODE_UNIT) ? SYM_I : (c == CODE_FIVE) ? SYM_V : SYM_X;
			PLACE_TENS:     s = (c == CODE_UNIT) ? SYM_X : (c == CODE_FIVE) ? SYM_L : SYM_C;
			PLACE_HUNDREDS: s = (c == CODE_UNIT) ? SYM_C : (c == CODE_FIVE) ? SYM_D : SYM_M;
			default:        s = SYM_M;
		endcase
		return s;
	endfunction

	// Highest place whose bit is set in a mask of nonzero digits.
	function automatic logic [1:0] top_place(input logic [3:0] mask);
		logic [1:0] p;
		if (mask[3]) p = PLACE_THOUSANDS;
		else if (mask[2]) p = PLACE_HUNDREDS;
		else if (mask[1]) p = PLACE_TENS;
		else p = PLACE_ONES;
		return p;
	endfunction

endpackage

/* rtl/rne_in_if.sv */
// Input channel of the Roman numeral encoder: one integer per word.
// Depends on rne_pkg for the field width.
`timescale 1ns / 1ps

interface rne_in_if;
	logic                        valid;
	logic                        ready;
	logic [rne_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

/* rtl/rne_out_if.sv */
// Output channel of the Roman numeral encoder: one ASCII symbol per word.
// Depends on rne_pkg for the field width.
`timescale 1ns / 1ps

interface rne_out_if;
	logic                         valid;
	logic                         ready;
	logic [rne_pkg::SYMBOL_W-1:0] symbol;
	logic                         last;

	modport source (output valid, output symbol, output last, input ready);
	modport sink (input valid, input symbol, input last, output ready);
endinterface

/* rtl/rne_digit_split.sv */
// Decimal digit splitter: repeated subtraction of 1000, 100 and 10 on one
// shared compare/subtract unit. Depends on rne_pkg.
`timescale 1ns / 1ps

module rne_digit_split (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rne_pkg::VALUE_W-1:0] value,
	output rne_pkg::split_t             split
);

	logic                        busy_q;
	logic                        done_q;
	logic [1:0]                  place_q;
	logic [rne_pkg::VALUE_W-1:0] rem_q;
	rne_pkg::digit_t             cnt_q;
	rne_pkg::digit_t [3:0]       digit_q;

	logic [rne_pkg::VALUE_W-1:0] weight;
	logic                        ge;
	logic [rne_pkg::VALUE_W-1:0] diff;

	// The shared unit: compare the remainder with the place weight and subtract.
	assign weight = rne_pkg::place_weight(place_q);
	assign ge     = rem_q >= weight;
	assign diff   = rem_q - weight;

	// Control: busy flag and the one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && !ge && place_q == rne_pkg::PLACE_TENS) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: saturate on load, then count subtractions per place.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= (value > rne_pkg::MAX_VALUE) ? rne_pkg::MAX_VALUE : value;
			place_q <= rne_pkg::PLACE_THOUSANDS;
			cnt_q   <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff;
				cnt_q <= cnt_q + 4'd1;
			end else begin
				digit_q[place_q] <= cnt_q;
				cnt_q            <= '0;
				if (place_q == rne_pkg::PLACE_TENS) begin
					digit_q[rne_pkg::PLACE_ONES] <= rem_q[3:0];
				end else begin
					place_q <= place_q - 2'd1;
				end
			end
		end
	end

	assign split.done  = done_q;
	assign split.digit = digit_q;

endmodule

/* rtl/roman_numeral_encoder_top.sv */
// Roman numeral encoder: takes one integer word and returns its numeral as
// ASCII symbol words, most significant first, the final one marked by last.
// Values above 3999 are converted as 3999 and zero yields no words. The
// block takes one integer at a time. After a word is accepted, one shared
// compare/subtract unit splits the value into digits by repeated subtraction;
// the symbols then leave at one per cycle while the consumer takes them, up
// to 15 of them, and the input is ready again from the edge at which the
// final symbol enters the output register. A zero word is taken and dropped.
// Depends on rne_pkg, rne_in_if, rne_out_if, rne_digit_split and the macro header.
`timescale 1ns / 1ps
`include "roman_numeral_encoder_top_macros.svh"

module roman_numeral_encoder_top (
	input  logic             clk,
	input  logic             arst_n,
	rne_in_if.sink           item,
	rne_out_if.source        numeral
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SPLIT = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [1:0]                   state_q;
	logic [1:0]                   place_q;
	logic [1:0]                   k_q;
	logic                         ovalid_q;
	logic                         last_q;
	logic [rne_pkg::SYMBOL_W-1:0] symbol_q;

	rne_pkg::split_t  split;
	logic             accept;
	logic             start;
	logic             take;
	logic             free;
	logic [3:0]       nz;
	logic [3:0]       below;
	rne_pkg::digit_t  cur_digit;
	rne_pkg::code_t   cur_code;
	rne_pkg::code_t   nxt_code;
	logic             has_next_in;
	logic             is_last;

	// Digit splitter.
	rne_digit_split u_split (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (item.value),
		.split  (split)
	);

	// Handshakes; a zero word is taken and dropped.
	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign start      = accept && (item.value != '0);
	assign take       = ovalid_q && numeral.ready;
	assign free       = !ovalid_q || take;

	// Pattern position lookup and end-of-numeral detection.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			nz[i] = (split.digit[i] != '0);
		end
		below       = nz & ((4'b0001 << place_q) - 4'b0001);
		cur_digit   = split.digit[place_q];
		cur_code    = rne_pkg::digit_code(cur_digit, k_q);
		nxt_code    = rne_pkg::digit_code(cur_digit, k_q + 2'd1);
		has_next_in = (k_q != 2'd3) && (nxt_code != rne_pkg::CODE_NONE);
		is_last     = !has_next_in && (below == 4'b0000);
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			place_q  <= rne_pkg::PLACE_ONES;
			k_q      <= 2'd0;
		end else begin
			if (take) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					if (split.done) begin
						state_q <= ST_EMIT;
						place_q <= rne_pkg::top_place(nz);
						k_q     <= 2'd0;
					end
				end
				ST_EMIT: begin
					if (free) begin
						ovalid_q <= 1'b1;
						if (has_next_in) begin
							k_q <= k_q + 2'd1;
						end else if (below != 4'b0000) begin
							place_q <= rne_pkg::top_place(below);
							k_q     <= 2'd0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && free) begin
			symbol_q <= rne_pkg::place_symbol(place_q, cur_code);
			last_q   <= is_last;
		end
	end

	assign numeral.valid  = ovalid_q;
	assign numeral.symbol = symbol_q;
	assign numeral.last   = last_q;

	// Checks on the sequencer.
	`RNE_ASSERT_NOW(a_done_in_split, split.done, state_q == ST_SPLIT, "split done outside split state")
	`RNE_ASSERT_NOW(a_emit_nonzero, state_q == ST_EMIT, cur_code != rne_pkg::CODE_NONE, "empty pattern position in emit")
	`RNE_ASSERT_NOW(a_end_marked, (state_q == ST_EMIT ##1 state_q == ST_IDLE), ovalid_q && last_q, "numeral ended without last")
	`RNE_ASSERT_NEXT(a_zero_dropped, accept && item.value == '0, state_q == ST_IDLE, "zero word started a conversion")

endmodule
